[hdl/lewc_pkg.sv]
// ----------------------------------------------------------------------------
// lewc_pkg: shared types and constants
// Default sizes, sum width helpers, state encodings and the job flag bundle
// passed from the hit front end to the divide back end.
// ----------------------------------------------------------------------------
package lewc_pkg;

	localparam int MAX_GROUP_DEF   = 256;
	localparam int COORD_BITS_DEF  = 16;
	localparam int ENERGY_BITS_DEF = 16;
	localparam int JOB_DEPTH       = 2;
	localparam int SUM_CAP_BITS    = 64;

	// hit counter holds 0..max_group
	function automatic int cnt_width(input int max_group);
		return $clog2(max_group + 1);
	endfunction

	function automatic int esum_width(input int energy_bits, input int max_group);
		return energy_bits + cnt_width(max_group);
	endfunction

	// weighted sums wrap at 64 bits
	function automatic int wsum_width(input int energy_bits, input int coord_bits,
		input int max_group);
		int w;
		w = energy_bits + coord_bits + cnt_width(max_group);
		return (w > SUM_CAP_BITS) ? SUM_CAP_BITS : w;
	endfunction

	typedef struct packed {
		logic overflow;
		logic last;
	} job_flags_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_CLOSE_OLD,
		F_MUL,
		F_ACCX,
		F_ACCY,
		F_CLOSE_END
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIVX,
		B_DIVY,
		B_DONE
	} back_state_t;

endpackage

[hdl/layer_energy_weighted_centroid.sv]
// ----------------------------------------------------------------------------
// layer_energy_weighted_centroid: per-layer energy-weighted hit centroid
// Groups consecutive calorimeter hits of equal z, sums energy and energy
// weighted x and y, and on each group close emits the truncated centroid.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake        Beat contents
//  -------  ---------------  -----------------------------------------------
//  hit      push / full      hit_energy, hit_x, hit_y, hit_z, end_of_event
//  result   empty / pop      centroid_x, centroid_y, layer_z, zero_energy,
//                            group_overflow, last_of_event
//
// Steps: a hit beat passes the front end in order (accept, multiply x,
//   accumulate x and multiply y, accumulate y), sharing the one
//   multiplier; each group close adds a state to queue its job, so a hit
//   that changes layer and ends the event passes both close states.
// The back end divides each group over W bits, x then y (W = weighted sum
//   width, 41 at default sizes: one restoring divide step per cycle), and
//   skips the divide for a zero-energy group.
// Stalls: a two-entry job queue parts front and back; the front holds full
//   high while the queue is full. A result register holds the finished beat
//   while the back end divides the next group.
// Reset: arst_n clears all group sums, empties the queue and clears the result valid flag.
//
module layer_energy_weighted_centroid import lewc_pkg::*; #(
	parameter int MAX_GROUP   = MAX_GROUP_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int ENERGY_BITS = ENERGY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [ENERGY_BITS-1:0]       hit_energy,
	input  logic signed [COORD_BITS-1:0] hit_x,
	input  logic signed [COORD_BITS-1:0] hit_y,
	input  logic signed [COORD_BITS-1:0] hit_z,
	input  logic                         end_of_event,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COORD_BITS-1:0] centroid_x,
	output logic signed [COORD_BITS-1:0] centroid_y,
	output logic signed [COORD_BITS-1:0] layer_z,
	output logic                         zero_energy,
	output logic                         group_overflow,
	output logic                         last_of_event
);

	localparam int ESUM_W = esum_width(ENERGY_BITS, MAX_GROUP);
	localparam int WSUM_W = wsum_width(ENERGY_BITS, COORD_BITS, MAX_GROUP);
	localparam int FLAG_W = $bits(job_flags_t);
	localparam int JOB_W  = ESUM_W + 2 * WSUM_W + COORD_BITS + FLAG_W;

	// front end -> queue
	logic                         fj_push;
	logic                         fj_full;
	logic [ESUM_W-1:0]            fj_esum;
	logic signed [WSUM_W-1:0]     fj_wx;
	logic signed [WSUM_W-1:0]     fj_wy;
	logic signed [COORD_BITS-1:0] fj_z;
	job_flags_t                   fj_flags;
	logic [JOB_W-1:0]             fj_data;

	// queue -> back end
	logic                         bj_pop;
	logic                         bj_empty;
	logic [JOB_W-1:0]             bj_data;
	logic [ESUM_W-1:0]            bj_esum;
	logic signed [WSUM_W-1:0]     bj_wx;
	logic signed [WSUM_W-1:0]     bj_wy;
	logic signed [COORD_BITS-1:0] bj_z;
	job_flags_t                   bj_flags;

	lewc_front #(
		.MAX_GROUP  (MAX_GROUP),
		.COORD_BITS (COORD_BITS),
		.ENERGY_BITS(ENERGY_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.hit_energy  (hit_energy),
		.hit_x       (hit_x),
		.hit_y       (hit_y),
		.hit_z       (hit_z),
		.end_of_event(end_of_event),
		.job_push    (fj_push),
		.job_full    (fj_full),
		.job_esum    (fj_esum),
		.job_wx      (fj_wx),
		.job_wy      (fj_wy),
		.job_z       (fj_z),
		.job_flags   (fj_flags)
	);

	// job word: energy sum, x sum, y sum, z, flags
	assign fj_data = {fj_esum, fj_wx, fj_wy, fj_z, fj_flags};

	lewc_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(JOB_DEPTH)
	) u_jobq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fj_push),
		.din   (fj_data),
		.full  (fj_full),
		.pop   (bj_pop),
		.dout  (bj_data),
		.empty (bj_empty)
	);

	assign {bj_esum, bj_wx, bj_wy, bj_z, bj_flags} = bj_data;

	lewc_back #(
		.MAX_GROUP  (MAX_GROUP),
		.COORD_BITS (COORD_BITS),
		.ENERGY_BITS(ENERGY_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_empty     (bj_empty),
		.job_pop       (bj_pop),
		.job_esum      (bj_esum),
		.job_wx        (bj_wx),
		.job_wy        (bj_wy),
		.job_z         (bj_z),
		.job_flags     (bj_flags),
		.empty         (empty),
		.pop           (pop),
		.centroid_x    (centroid_x),
		.centroid_y    (centroid_y),
		.layer_z       (layer_z),
		.zero_energy   (zero_energy),
		.group_overflow(group_overflow),
		.last_of_event (last_of_event)
	);

endmodule

[hdl/lewc_fifo.sv]
// ----------------------------------------------------------------------------
// lewc_fifo: short job queue
// Small register FIFO between the accumulating front end and the divider.
// ----------------------------------------------------------------------------
module lewc_fifo import lewc_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = JOB_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	// the front end waits on full, so it never pushes into a full queue
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into full queue");

endmodule

[hdl/lewc_front.sv]
// ----------------------------------------------------------------------------
// lewc_front: hit intake and group accumulation
// Detects layer changes, accumulates energy and weighted sums with one shared
// multiplier, and queues a job whenever a group closes.
// ----------------------------------------------------------------------------
module lewc_front import lewc_pkg::*; #(
	parameter int MAX_GROUP   = MAX_GROUP_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int ENERGY_BITS = ENERGY_BITS_DEF,
	localparam int CNT_W  = cnt_width(MAX_GROUP),
	localparam int ESUM_W = esum_width(ENERGY_BITS, MAX_GROUP),
	localparam int WSUM_W = wsum_width(ENERGY_BITS, COORD_BITS, MAX_GROUP)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [ENERGY_BITS-1:0]       hit_energy,
	input  logic signed [COORD_BITS-1:0] hit_x,
	input  logic signed [COORD_BITS-1:0] hit_y,
	input  logic signed [COORD_BITS-1:0] hit_z,
	input  logic                         end_of_event,
	output logic                         job_push,
	input  logic                         job_full,
	output logic [ESUM_W-1:0]            job_esum,
	output logic signed [WSUM_W-1:0]     job_wx,
	output logic signed [WSUM_W-1:0]     job_wy,
	output logic signed [COORD_BITS-1:0] job_z,
	output job_flags_t                   job_flags
);

	localparam int PROD_W = ENERGY_BITS + COORD_BITS;

	front_state_t                 st_q;
	front_state_t                 st_d;
	logic                         accept;
	logic [ENERGY_BITS-1:0]       e_q;
	logic signed [COORD_BITS-1:0] x_q;
	logic signed [COORD_BITS-1:0] y_q;
	logic signed [COORD_BITS-1:0] z_in_q;
	logic                         eoe_q;
	logic signed [COORD_BITS-1:0] mul_coord;
	logic signed [PROD_W:0]       prod_full;
	logic signed [PROD_W-1:0]     prod_q;
	logic                         add_q;
	logic [ESUM_W-1:0]            esum_q;
	logic signed [WSUM_W-1:0]     wx_q;
	logic signed [WSUM_W-1:0]     wy_q;
	logic signed [COORD_BITS-1:0] gz_q;
	logic                         open_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         ovf_q;

	assign full   = (st_q != F_IDLE);
	assign accept = push && (st_q == F_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		job_push = 1'b0;
		unique case (st_q)
			F_IDLE: begin
				if (push) begin
					st_d = (open_q && (hit_z != gz_q)) ? F_CLOSE_OLD : F_MUL;
				end
			end
			F_CLOSE_OLD: begin
				if (!job_full) begin
					job_push = 1'b1;
					st_d     = F_MUL;
				end
			end
			F_MUL:  st_d = F_ACCX;
			F_ACCX: st_d = F_ACCY;
			F_ACCY: st_d = eoe_q ? F_CLOSE_END : F_IDLE;
			F_CLOSE_END: begin
				if (!job_full) begin
					job_push = 1'b1;
					st_d     = F_IDLE;
				end
			end
			default: st_d = F_IDLE;
		endcase
	end

	// one multiplier: e*x in F_MUL, e*y in F_ACCX
	assign mul_coord = (st_q == F_MUL) ? x_q : y_q;
	assign prod_full = $signed({1'b0, e_q}) * mul_coord;

	always_ff @(posedge clk) begin
		if (accept) begin
			e_q    <= hit_energy;
			x_q    <= hit_x;
			y_q    <= hit_y;
			z_in_q <= hit_z;
			eoe_q  <= end_of_event;
		end
		prod_q <= $signed(prod_full[PROD_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esum_q <= '0;
			wx_q   <= '0;
			wy_q   <= '0;
			gz_q   <= '0;
			open_q <= 1'b0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			add_q  <= 1'b0;
		end else begin
			unique case (st_q) inside
				F_CLOSE_OLD, F_CLOSE_END: begin
					if (job_push) begin
						esum_q <= '0;
						wx_q   <= '0;
						wy_q   <= '0;
						gz_q   <= '0;
						open_q <= 1'b0;
						cnt_q  <= '0;
						ovf_q  <= 1'b0;
					end
				end
				F_MUL: begin
					if (!open_q) begin
						open_q <= 1'b1;
						gz_q   <= z_in_q;
					end
				end
				F_ACCX: begin
					// hits past the group limit are dropped
					if (cnt_q >= CNT_W'(MAX_GROUP)) begin
						ovf_q <= 1'b1;
						add_q <= 1'b0;
					end else begin
						cnt_q  <= cnt_q + 1'b1;
						esum_q <= esum_q + ESUM_W'(e_q);
						wx_q   <= wx_q + WSUM_W'(prod_q);
						add_q  <= 1'b1;
					end
				end
				F_ACCY: begin
					if (add_q) begin
						wy_q <= wy_q + WSUM_W'(prod_q);
					end
				end
				default: ;
			endcase
		end
	end

	assign job_esum           = esum_q;
	assign job_wx             = wx_q;
	assign job_wy             = wy_q;
	assign job_z              = gz_q;
	assign job_flags.overflow = ovf_q;
	assign job_flags.last     = (st_q == F_CLOSE_END);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_GROUP))
		else $error("hit count past group limit");

	a_ovf_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (cnt_q == CNT_W'(MAX_GROUP)))
		else $error("overflow flag without full group");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |=> (!open_q && (cnt_q == '0) && (esum_q == '0)))
		else $error("group not cleared after close");

endmodule

[hdl/lewc_back.sv]
// ----------------------------------------------------------------------------
// lewc_back: centroid divide and result register
// Takes closed-group jobs, divides both weighted sums by the energy sum with
// one radix-2 restoring divider, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module lewc_back import lewc_pkg::*; #(
	parameter int MAX_GROUP   = MAX_GROUP_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int ENERGY_BITS = ENERGY_BITS_DEF,
	localparam int ESUM_W = esum_width(ENERGY_BITS, MAX_GROUP),
	localparam int WSUM_W = wsum_width(ENERGY_BITS, COORD_BITS, MAX_GROUP)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_empty,
	output logic                         job_pop,
	input  logic [ESUM_W-1:0]            job_esum,
	input  logic signed [WSUM_W-1:0]     job_wx,
	input  logic signed [WSUM_W-1:0]     job_wy,
	input  logic signed [COORD_BITS-1:0] job_z,
	input  job_flags_t                   job_flags,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COORD_BITS-1:0] centroid_x,
	output logic signed [COORD_BITS-1:0] centroid_y,
	output logic signed [COORD_BITS-1:0] layer_z,
	output logic                         zero_energy,
	output logic                         group_overflow,
	output logic                         last_of_event
);

	localparam int STEP_W = $clog2(WSUM_W);

	back_state_t                  bst_q;
	back_state_t                  bst_d;
	logic                         out_valid_q;
	logic                         out_free;
	logic                         step_last;
	logic [ESUM_W-1:0]            div_q;
	logic signed [WSUM_W-1:0]     wy_q;
	logic                         negx_q;
	logic                         negy_q;
	logic signed [COORD_BITS-1:0] z_q;
	job_flags_t                   flags_q;
	logic                         zero_q;
	logic [WSUM_W-1:0]            dvd_q;
	logic [ESUM_W-1:0]            rem_q;
	logic [STEP_W-1:0]            step_q;
	logic [COORD_BITS-1:0]        cx_q;
	logic [COORD_BITS-1:0]        cy_q;
	logic [WSUM_W-1:0]            mag_x;
	logic [WSUM_W-1:0]            mag_y;
	logic [ESUM_W:0]              shifted;
	logic                         ge;
	logic [ESUM_W:0]              diff;
	logic [ESUM_W-1:0]            rem_d;
	logic [WSUM_W-1:0]            dvd_d;
	logic [COORD_BITS-1:0]        q_low;
	logic                         q_neg;
	logic [COORD_BITS-1:0]        q_signed;
	logic [COORD_BITS-1:0]        out_cx_q;
	logic [COORD_BITS-1:0]        out_cy_q;
	logic signed [COORD_BITS-1:0] out_z_q;
	logic                         out_zero_q;
	job_flags_t                   out_flags_q;

	assign out_free  = !out_valid_q || pop;
	assign step_last = (step_q == STEP_W'(WSUM_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q <= B_IDLE;
		end else begin
			bst_q <= bst_d;
		end
	end

	always_comb begin
		bst_d   = bst_q;
		job_pop = 1'b0;
		unique case (bst_q)
			B_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					bst_d   = (job_esum == '0) ? B_DONE : B_DIVX;
				end
			end
			B_DIVX: if (step_last) bst_d = B_DIVY;
			B_DIVY: if (step_last) bst_d = B_DONE;
			B_DONE: if (out_free) bst_d = B_IDLE;
			default: bst_d = B_IDLE;
		endcase
	end

	// magnitudes of the signed sums
	assign mag_x = job_wx[WSUM_W-1] ? (~job_wx + 1'b1) : job_wx;
	assign mag_y = wy_q[WSUM_W-1] ? (~wy_q + 1'b1) : wy_q;

	// one restoring step per cycle
	assign shifted  = {rem_q, dvd_q[WSUM_W-1]};
	assign ge       = (shifted >= {1'b0, div_q});
	assign diff     = shifted - {1'b0, div_q};
	assign rem_d    = ge ? diff[ESUM_W-1:0] : shifted[ESUM_W-1:0];
	assign dvd_d    = {dvd_q[WSUM_W-2:0], ge};
	assign q_low    = dvd_d[COORD_BITS-1:0];
	assign q_neg    = (bst_q == B_DIVX) ? negx_q : negy_q;
	assign q_signed = q_neg ? (~q_low + 1'b1) : q_low;

	always_ff @(posedge clk) begin
		unique case (bst_q)
			B_IDLE: begin
				if (job_pop) begin
					div_q   <= job_esum;
					wy_q    <= job_wy;
					negx_q  <= job_wx[WSUM_W-1];
					negy_q  <= job_wy[WSUM_W-1];
					z_q     <= job_z;
					flags_q <= job_flags;
					zero_q  <= (job_esum == '0);
					cx_q    <= '0;
					cy_q    <= '0;
					dvd_q   <= mag_x;
					rem_q   <= '0;
					step_q  <= '0;
				end
			end
			B_DIVX: begin
				if (step_last) begin
					cx_q   <= q_signed;
					dvd_q  <= mag_y;
					rem_q  <= '0;
					step_q <= '0;
				end else begin
					dvd_q  <= dvd_d;
					rem_q  <= rem_d;
					step_q <= step_q + 1'b1;
				end
			end
			B_DIVY: begin
				dvd_q  <= dvd_d;
				rem_q  <= rem_d;
				step_q <= step_q + 1'b1;
				if (step_last) begin
					cy_q <= q_signed;
				end
			end
			B_DONE: begin
				if (out_free) begin
					out_cx_q    <= cx_q;
					out_cy_q    <= cy_q;
					out_z_q     <= z_q;
					out_zero_q  <= zero_q;
					out_flags_q <= flags_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((bst_q == B_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty          = !out_valid_q;
	assign centroid_x     = $signed(out_cx_q);
	assign centroid_y     = $signed(out_cy_q);
	assign layer_z        = out_z_q;
	assign zero_energy    = out_zero_q;
	assign group_overflow = out_flags_q.overflow;
	assign last_of_event  = out_flags_q.last;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		((bst_q == B_DIVX) || (bst_q == B_DIVY)) |-> (div_q != '0))
		else $error("divide started with zero energy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((bst_q == B_DIVX) || (bst_q == B_DIVY)) |-> (rem_q < div_q))
		else $error("partial remainder not below divisor");

endmodule

[bench/tb_layer_energy_weighted_centroid.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_layer_energy_weighted_centroid: self-checking bench for the layer centroid
// Drives hit beats through the push/full side and pops centroid beats from the
// empty/pop side, both with random idle cycles. A scoreboard class tracks the
// open layer group, predicts every centroid and checks each popped beat.
// ----------------------------------------------------------------------------
module tb_layer_energy_weighted_centroid import lewc_pkg::*; ();

	localparam int RX_HOLD_CYCLES = 1500;	// long pop hold-off, fills the job queue
	localparam int DRAIN_CYCLES   = 300;	// exceeds one group's pass through the divider

	typedef struct packed {
		logic signed [COORD_BITS_DEF-1:0] cx;
		logic signed [COORD_BITS_DEF-1:0] cy;
		logic signed [COORD_BITS_DEF-1:0] lz;
		logic                             zero;
		logic                             ovf;
		logic                             last;
	} centroid_t;

	// Tracks the open layer group and queues the centroid each close produces.
	class centroid_scoreboard;
		longint                           energy_sum;
		longint                           x_moment;
		longint                           y_moment;
		logic signed [COORD_BITS_DEF-1:0] group_z;
		bit                               group_open;
		int                               hit_count;
		bit                               overflow_seen;
		centroid_t                        centroid_q[$];
		int                               errors;

		function new();
			errors = 0;
			clear_group();
		endfunction

		function void clear_group();
			energy_sum    = 0;
			x_moment      = 0;
			y_moment      = 0;
			group_z       = '0;
			group_open    = 0;
			hit_count     = 0;
			overflow_seen = 0;
		endfunction

		// longint division truncates toward zero, as the block must
		function centroid_t close_group(bit last);
			centroid_t c;
			longint    qx;
			longint    qy;
			if (energy_sum == 0) begin
				c.cx   = '0;
				c.cy   = '0;
				c.zero = 1'b1;
			end else begin
				qx     = x_moment / energy_sum;
				qy     = y_moment / energy_sum;
				c.cx   = qx[COORD_BITS_DEF-1:0];
				c.cy   = qy[COORD_BITS_DEF-1:0];
				c.zero = 1'b0;
			end
			c.lz   = group_z;
			c.ovf  = overflow_seen;
			c.last = last;
			clear_group();
			return c;
		endfunction

		function void note_hit(logic [ENERGY_BITS_DEF-1:0] e, logic signed [COORD_BITS_DEF-1:0] x,
			logic signed [COORD_BITS_DEF-1:0] y, logic signed [COORD_BITS_DEF-1:0] z,
			logic eoe);
			// new z closes the open layer first
			if (group_open && z != group_z)
				centroid_q.insert(centroid_q.size(), close_group(1'b0));
			if (!group_open) begin
				group_open = 1;
				group_z    = z;
			end
			// past MAX_GROUP hits are dropped, flag sticks until close
			if (hit_count >= MAX_GROUP_DEF) begin
				overflow_seen = 1;
			end else begin
				hit_count++;
				energy_sum += longint'(e);
				x_moment   += longint'(e) * longint'(x);
				y_moment   += longint'(e) * longint'(y);
			end
			if (eoe)
				centroid_q.insert(centroid_q.size(), close_group(1'b1));
		endfunction

		function void check_result(centroid_t got);
			centroid_t want;
			if (centroid_q.size() == 0) begin
				$error("unexpected centroid beat: x=%0d y=%0d z=%0d", got.cx, got.cy, got.lz);
				errors++;
				return;
			end
			want = centroid_q.pop_front();
			if (got.cx !== want.cx) begin
				$error("centroid_x: expected %0d, got %0d", want.cx, got.cx);
				errors++;
			end
			if (got.cy !== want.cy) begin
				$error("centroid_y: expected %0d, got %0d", want.cy, got.cy);
				errors++;
			end
			if (got.lz !== want.lz) begin
				$error("layer_z: expected %0d, got %0d", want.lz, got.lz);
				errors++;
			end
			if (got.zero !== want.zero) begin
				$error("zero_energy: expected %0b, got %0b", want.zero, got.zero);
				errors++;
			end
			if (got.ovf !== want.ovf) begin
				$error("group_overflow: expected %0b, got %0b", want.ovf, got.ovf);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last_of_event: expected %0b, got %0b", want.last, got.last);
				errors++;
			end
		endfunction

		function int waiting();
			return centroid_q.size();
		endfunction
	endclass

	logic                              clk          = 1'b0;
	logic                              arst_n       = 1'b0;
	logic                              push         = 1'b0;
	logic                              full;
	logic [ENERGY_BITS_DEF-1:0]        hit_energy   = '0;
	logic signed [COORD_BITS_DEF-1:0]  hit_x        = '0;
	logic signed [COORD_BITS_DEF-1:0]  hit_y        = '0;
	logic signed [COORD_BITS_DEF-1:0]  hit_z        = '0;
	logic                              end_of_event = 1'b0;
	logic                              empty;
	logic                              pop          = 1'b0;
	logic signed [COORD_BITS_DEF-1:0]  centroid_x;
	logic signed [COORD_BITS_DEF-1:0]  centroid_y;
	logic signed [COORD_BITS_DEF-1:0]  layer_z;
	logic                              zero_energy;
	logic                              group_overflow;
	logic                              last_of_event;

	centroid_scoreboard sb;
	bit                 quiet         = 0;	// no idling on either side
	bit                 stall_request = 0;	// receiver starts its long hold-off
	int                 hits_sent     = 0;

	always #2 clk = ~clk;

	layer_energy_weighted_centroid DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.hit_energy     (hit_energy),
		.hit_x          (hit_x),
		.hit_y          (hit_y),
		.hit_z          (hit_z),
		.end_of_event   (end_of_event),
		.empty          (empty),
		.pop            (pop),
		.centroid_x     (centroid_x),
		.centroid_y     (centroid_y),
		.layer_z        (layer_z),
		.zero_energy    (zero_energy),
		.group_overflow (group_overflow),
		.last_of_event  (last_of_event)
	);

	// Offer one hit beat; push stays high into the next call unless it idles.
	task automatic send_hit(input logic [ENERGY_BITS_DEF-1:0] e,
		input logic signed [COORD_BITS_DEF-1:0] x, input logic signed [COORD_BITS_DEF-1:0] y,
		input logic signed [COORD_BITS_DEF-1:0] z, input logic eoe);
		while (!quiet && $urandom_range(99) < 24) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push         <= 1'b1;
		hit_energy   <= e;
		hit_x        <= x;
		hit_y        <= y;
		hit_z        <= z;
		end_of_event <= eoe;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_hit(e, x, y, z, eoe);
		hits_sent++;
		@(negedge clk);
	endtask

	// Sender pause: nothing offered until every centroid has been popped.
	task automatic wait_drained();
		push <= 1'b0;
		@(negedge clk);
		while (sb.waiting() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [COORD_BITS_DEF-1:0] rand_coord();
		return COORD_BITS_DEF'($urandom);
	endfunction

	// Energies lean on zero, full scale and tiny weights.
	function automatic logic [ENERGY_BITS_DEF-1:0] rand_energy();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return ENERGY_BITS_DEF'($urandom_range(15));
			default: return ENERGY_BITS_DEF'($urandom);
		endcase
	endfunction

	// Well-formed event: layers of equal-z hits, z changing per layer, last
	// hit flagged end of event.
	task automatic send_event(input int layers, input int max_hits);
		logic signed [COORD_BITS_DEF-1:0] z;
		int                               n;
		z = rand_coord();
		for (int l = 0; l < layers; l++) begin
			n = $urandom_range(max_hits, 1);
			for (int k = 0; k < n; k++)
				send_hit(rand_energy(), rand_coord(), rand_coord(), z,
					(l == layers - 1) && (k == n - 1));
			z += COORD_BITS_DEF'($urandom_range(40, 1));
		end
	endtask

	// Noise: z hops among two values and random ones, end flag at random.
	task automatic send_noise(input int n);
		logic signed [COORD_BITS_DEF-1:0] za;
		logic signed [COORD_BITS_DEF-1:0] zb;
		logic signed [COORD_BITS_DEF-1:0] z;
		za = rand_coord();
		zb = rand_coord();
		repeat (n) begin
			case ($urandom_range(3))
				0, 1: z = za;
				2: z = zb;
				default: z = rand_coord();
			endcase
			send_hit(rand_energy(), rand_coord(), rand_coord(), z, $urandom_range(3) == 0);
		end
	endtask

	// Result side: pop changes on the falling edge, long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (stall_request) begin
				pop <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				stall_request = 0;
			end else
				pop <= quiet || ($urandom_range(99) >= 24);
		end
	end

	// Result beats are taken at the rising edge where pop and !empty meet.
	always @(posedge clk) begin : result_mon
		centroid_t got;
		if (arst_n && pop && !empty) begin
			got.cx   = centroid_x;
			got.cy   = centroid_y;
			got.lz   = layer_z;
			got.zero = zero_energy;
			got.ovf  = group_overflow;
			got.last = last_of_event;
			sb.check_result(got);
		end
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#8_000_000;
		$display("FAIL layer_energy_weighted_centroid");
		$finish;
	end

	initial begin
		int  base;
		int  done;
		bit  hold_fired;
		bit  mid_pause;
		logic signed [COORD_BITS_DEF-1:0] za;
		logic signed [COORD_BITS_DEF-1:0] zb;
		sb         = new();
		hold_fired = 0;
		mid_pause  = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: single-hit event at z 0 (matches the cleared group z)
		send_hit(16'd100, 16'sd10, -16'sd10, 16'sd0, 1'b1);
		// zero energy, lone hit
		send_hit(16'd0, 16'sd5, 16'sd5, 16'sd7, 1'b1);
		// full-scale energy at coordinate extremes, two hits on top layer
		send_hit(16'hFFFF, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0);
		send_hit(16'hFFFF, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0);
		// layer change closes the group: -1.5 and +1.5 truncate toward zero
		send_hit(16'd1, -16'sd3, 16'sd3, -16'sd32768, 1'b0);
		send_hit(16'd1, 16'sd0, 16'sd0, -16'sd32768, 1'b0);
		// new layer and end of event on one hit: two beats from one input
		send_hit(16'd3, -16'sd32768, 16'sd32767, -16'sd1, 1'b1);
		// group of zero-energy hits after a weighted layer
		send_hit(16'd2, 16'sd1, -16'sd1, 16'sd5, 1'b0);
		send_hit(16'd0, 16'sd100, 16'sd100, 16'sd6, 1'b0);
		send_hit(16'd0, -16'sd100, 16'sd9, 16'sd6, 1'b1);
		// small negative fraction truncates to zero
		send_hit(16'hFFFF, -16'sd1, 16'sd1, -16'sd32768, 1'b0);
		send_hit(16'd1, 16'sd32767, -16'sd32768, -16'sd32768, 1'b1);
		wait_drained();

		// Group length: exactly MAX_GROUP hits, then a longer group whose
		// dropped hits carry heavy energy so a missed drop shows up.
		za = rand_coord();
		zb = za + 16'sd1;
		for (int k = 0; k < MAX_GROUP_DEF; k++)
			send_hit(rand_energy(), rand_coord(), rand_coord(), za, 1'b0);
		for (int k = 0; k < MAX_GROUP_DEF + 4; k++)
			send_hit((k < MAX_GROUP_DEF) ? 16'd1 : 16'hFFFF, rand_coord(), rand_coord(), zb,
				k == MAX_GROUP_DEF + 3);
		wait_drained();

		// Random: mostly well-formed events, some noise
		base = hits_sent;
		done = 0;
		while (done < 220) begin
			quiet = (done >= 80) && (done < 130);
			if (!hold_fired && done >= 30) begin
				hold_fired    = 1;
				stall_request = 1;
			end
			if (!mid_pause && done >= 160) begin
				mid_pause = 1;
				wait_drained();
			end
			if ($urandom_range(4) != 0)
				send_event($urandom_range(4, 1), ($urandom_range(7) == 0) ? 12 : 4);
			else
				send_noise($urandom_range(8, 1));
			done = hits_sent - base;
		end
		quiet = 0;
		// close whatever noise left open
		send_hit(rand_energy(), rand_coord(), rand_coord(), rand_coord(), 1'b1);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (sb.errors == 0)
			$display("PASS layer_energy_weighted_centroid");
		else
			$display("FAIL layer_energy_weighted_centroid");
		$finish;
	end

endmodule
